FILE: rtl/adsc_pkg.sv
// Package for the advertising data scanner: types, constants and register indexes.
package adsc_pkg;

   localparam int MAX_NAME_BYTES_DEFAULT = 32;
   localparam int CMD_QUEUE_DEPTH        = 2;
   localparam int RSP_QUEUE_DEPTH        = 2;

   localparam logic [7:0] TYPE_NAME  = 8'h09;
   localparam logic [7:0] TYPE_MANUF = 8'hff;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LOW     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_MID_LOW = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_MID_HI  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_HIGH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUF_LENGTH = 3'd5;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   // classified payload byte, as queued between front and back
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
      logic       is_name;
      logic       is_manuf;
   } cmd_type;

   typedef struct packed {
      logic       name_match;
      logic       manufacturer_found;
      logic [7:0] manufacturer_offset;
   } rsp_type;

endpackage

FILE: rtl/adsc_fifo.sv
// Small register-based queue used between the scanner stages.
module adsc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/adsc_front.sv
// Front end: takes payload bytes and tags element type codes before queueing.
module adsc_front
   import adsc_pkg::*;
(
   input  logic       req_push,
   input  logic [7:0] req_payload_byte,
   input  logic       req_last_byte,
   output logic       req_full,
   input  logic       queue_full,
   output logic       queue_push,
   output cmd_type    queue_item
);

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

   always_comb begin
      queue_item.payload_byte = req_payload_byte;
      queue_item.last_byte    = req_last_byte;
      queue_item.is_name      = (req_payload_byte == TYPE_NAME);
      queue_item.is_manuf     = (req_payload_byte == TYPE_MANUF);
   end

endmodule

FILE: rtl/adsc_back.sv
// Back end: walks length-type-value elements, compares the name, builds results.
module adsc_back
   import adsc_pkg::*;
#(
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data,
   input  cmd_type                cmd,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output rsp_type                rsp
);

   localparam int NIDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

   logic [5:0] name_length_ff;
   logic [7:0] manuf_length_ff;
   logic [7:0] name_ff [MAX_NAME_BYTES];

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [5:0] cmp_idx_ff, cmp_idx_in;
   logic       comparing_ff, comparing_in;
   logic       decided_ff, decided_in;
   logic       result_ff, result_in;
   logic       seen_ff, seen_in;
   logic [7:0] manuf_pos_ff, manuf_pos_in;
   logic [7:0] byte_pos_ff, byte_pos_in;

   logic [7:0] rem_dec;
   logic [5:0] idx_inc;
   logic [7:0] name_sel;
   logic       take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         name_length_ff  <= '0;
         manuf_length_ff <= '0;
         for (int i = 0; i < MAX_NAME_BYTES; i++) begin
            name_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_NAME_LENGTH) begin
            name_length_ff <= csr_data[5:0];
         end
         if (csr_index == CSR_MANUF_LENGTH) begin
            manuf_length_ff <= csr_data[7:0];
         end
         for (int i = 0; i < MAX_NAME_BYTES; i++) begin
            if (csr_index == CSR_INDEX_W'(CSR_NAME_LOW + i / 8)) begin
               name_ff[i] <= csr_data[8 * (i % 8) +: 8];
            end
         end
      end
   end

   assign take     = !cmd_empty && (!cmd.last_byte || !rsp_full);
   assign cmd_pop  = take;
   assign rsp_push = take && cmd.last_byte;
   assign rem_dec  = remaining_ff - 8'd1;
   assign idx_inc  = cmp_idx_ff + 6'd1;
   assign name_sel = name_ff[cmp_idx_ff[NIDX_W-1:0]];

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      cmp_idx_in   = cmp_idx_ff;
      comparing_in = comparing_ff;
      decided_in   = decided_ff;
      result_in    = result_ff;
      seen_in      = seen_ff;
      manuf_pos_in = manuf_pos_ff;
      byte_pos_in  = byte_pos_ff;
      rsp          = '0;

      if (take) begin
         case (phase_ff)
            PH_TYPE: begin
               remaining_in = rem_dec;
               if (!decided_ff && !comparing_ff && cmd.is_name &&
                   rem_dec == {2'b00, name_length_ff}) begin
                  cmp_idx_in = '0;
                  if (rem_dec == 8'd0) begin
                     decided_in = 1'b1;
                     result_in  = 1'b1;
                  end else begin
                     comparing_in = 1'b1;
                  end
               end
               if (!seen_ff && cmd.is_manuf && rem_dec == manuf_length_ff) begin
                  seen_in      = 1'b1;
                  manuf_pos_in = byte_pos_ff + 8'd1;
               end
               phase_in = (rem_dec == 8'd0) ? PH_LEN : PH_DATA;
            end
            PH_DATA: begin
               if (comparing_ff) begin
                  // out-of-range position or differing byte ends the compare
                  if (cmp_idx_ff >= 6'(MAX_NAME_BYTES) || cmd.payload_byte != name_sel) begin
                     decided_in   = 1'b1;
                     result_in    = 1'b0;
                     comparing_in = 1'b0;
                  end else begin
                     cmp_idx_in = idx_inc;
                     if (idx_inc == name_length_ff) begin
                        decided_in   = 1'b1;
                        result_in    = 1'b1;
                        comparing_in = 1'b0;
                     end
                  end
               end
               remaining_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_LEN;
               end
            end
            default: begin
               remaining_in = cmd.payload_byte;
               phase_in     = PH_TYPE;
            end
         endcase
         byte_pos_in = byte_pos_ff + 8'd1;

         if (cmd.last_byte) begin
            rsp.name_match          = decided_in && result_in;
            rsp.manufacturer_found  = seen_in;
            rsp.manufacturer_offset = seen_in ? manuf_pos_in : 8'd0;
            phase_in     = PH_LEN;
            remaining_in = '0;
            cmp_idx_in   = '0;
            comparing_in = 1'b0;
            decided_in   = 1'b0;
            result_in    = 1'b0;
            seen_in      = 1'b0;
            manuf_pos_in = '0;
            byte_pos_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN;
         remaining_ff <= '0;
         cmp_idx_ff   <= '0;
         comparing_ff <= 1'b0;
         decided_ff   <= 1'b0;
         result_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         manuf_pos_ff <= '0;
         byte_pos_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         cmp_idx_ff   <= cmp_idx_in;
         comparing_ff <= comparing_in;
         decided_ff   <= decided_in;
         result_ff    <= result_in;
         seen_ff      <= seen_in;
         manuf_pos_ff <= manuf_pos_in;
         byte_pos_ff  <= byte_pos_in;
      end
   end

   a_cmp_not_decided: assert property (@(posedge clock) disable iff (reset)
      !(comparing_ff && decided_ff))
      else $error("name compare still running after verdict");

   a_manuf_pos_clear: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (manuf_pos_ff == 8'd0))
      else $error("manufacturer position set without a found element");

   a_rsp_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written into a full queue");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && cmd.last_byte) |=> (phase_ff == PH_LEN && byte_pos_ff == 8'd0 && !seen_ff))
      else $error("scan state not cleared after payload end");

endmodule

FILE: rtl/advertising_data_scanner_core.sv
// Path: a last byte is registered in the command queue, then its result in the result
// queue, before the result is on the rsp_ ports; it can then be popped.
// Throughput: one payload byte per cycle, set by the element walker
// in the back end; a full result queue stalls only last bytes.
// Reset: synchronous, active high; clears the scan state, both queues and all
// configuration registers (name length, name bytes, manufacturer length) to zero.
// Top level of the advertising data scanner.
module advertising_data_scanner_core
   import adsc_pkg::*;
#(
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_payload_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_name_match,
   output logic                   rsp_manufacturer_found,
   output logic [7:0]             rsp_manufacturer_offset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data
);

   cmd_type cmd_wr, cmd_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    cmd_push, cmd_pop, cmd_empty, cmd_full;
   logic    rsp_push, rsp_full;

   assign csr_ready = 1'b1;

   adsc_front u_front (
      .req_push         (req_push),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .req_full         (req_full),
      .queue_full       (cmd_full),
      .queue_push       (cmd_push),
      .queue_item       (cmd_wr)
   );

   adsc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty),
      .full    (cmd_full)
   );

   adsc_back #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   adsc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty),
      .full    (rsp_full)
   );

   assign rsp_name_match          = rsp_rd.name_match;
   assign rsp_manufacturer_found  = rsp_rd.manufacturer_found;
   assign rsp_manufacturer_offset = rsp_rd.manufacturer_offset;

endmodule

FILE: verif/advertising_data_scanner_checker.sv
`timescale 1ns / 1ps
// Checker for the advertising data scanner core: watches all channels, predicts and compares results.
module advertising_data_scanner_checker
   import adsc_pkg::*;
#(
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic [7:0]             req_payload_byte,
   input  logic                   req_last_byte,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic                   rsp_name_match,
   input  logic                   rsp_manufacturer_found,
   input  logic [7:0]             rsp_manufacturer_offset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data,
   output int                     error_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     name_hits,
   output int                     manuf_hits
);

   // register copies
   logic [5:0]  name_length;
   logic [63:0] name_words [4];
   logic [7:0]  manuf_length;

   // element walker state
   phase_type   phase;
   logic [7:0]  remaining;
   logic [5:0]  cmp_pos;
   logic        comparing;
   logic        decided;
   logic        name_ok;
   logic        manuf_seen;
   logic [7:0]  manuf_pos;
   logic [7:0]  byte_pos;

   rsp_type     scan_results_q[$];
   rsp_type     want;
   int          errors;
   int          results;
   int          names;
   int          manufs;

   task automatic clear_scan();
      phase      = PH_LEN;
      remaining  = '0;
      cmp_pos    = '0;
      comparing  = 1'b0;
      decided    = 1'b0;
      name_ok    = 1'b0;
      manuf_seen = 1'b0;
      manuf_pos  = '0;
      byte_pos   = '0;
   endtask

   task automatic settle_name(input logic ok);
      decided   = 1'b1;
      name_ok   = ok;
      comparing = 1'b0;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic last);
      rsp_type res;
      case (phase)
         PH_TYPE: begin
            remaining = remaining - 8'd1;
            if (!decided && !comparing && b == TYPE_NAME &&
                remaining == {2'b00, name_length}) begin
               cmp_pos = '0;
               if (remaining == 8'd0) settle_name(1'b1);
               else comparing = 1'b1;
            end
            if (!manuf_seen && b == TYPE_MANUF && remaining == manuf_length) begin
               manuf_seen = 1'b1;
               manuf_pos  = byte_pos + 8'd1;
            end
            phase = (remaining == 8'd0) ? PH_LEN : PH_DATA;
         end
         PH_DATA: begin
            if (comparing) begin
               if (cmp_pos >= MAX_NAME_BYTES ||
                   b != name_words[cmp_pos[4:3]][{cmp_pos[2:0], 3'b000} +: 8]) begin
                  settle_name(1'b0);
               end else begin
                  cmp_pos = cmp_pos + 6'd1;
                  if (cmp_pos == name_length) settle_name(1'b1);
               end
            end
            remaining = remaining - 8'd1;
            if (remaining == 8'd0) phase = PH_LEN;
         end
         // length phase, and the unused phase code behaves the same
         default: begin
            remaining = b;
            phase     = PH_TYPE;
         end
      endcase
      byte_pos = byte_pos + 8'd1;
      if (last) begin
         res.name_match          = decided && name_ok;
         res.manufacturer_found  = manuf_seen;
         res.manufacturer_offset = manuf_seen ? manuf_pos : 8'd0;
         scan_results_q.push_back(res);
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         name_length  = '0;
         manuf_length = '0;
         for (int w = 0; w < 4; w++) name_words[w] = '0;
         clear_scan();
         scan_results_q.delete();
         errors  = 0;
         results = 0;
         names   = 0;
         manufs  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NAME_LENGTH:  name_length   = csr_data[5:0];
               CSR_NAME_LOW:     name_words[0] = csr_data;
               CSR_NAME_MID_LOW: name_words[1] = csr_data;
               CSR_NAME_MID_HI:  name_words[2] = csr_data;
               CSR_NAME_HIGH:    name_words[3] = csr_data;
               CSR_MANUF_LENGTH: manuf_length  = csr_data[7:0];
               default: ;
            endcase
         end
         // result side first: a result never leaves in the cycle its last byte arrives
         if (rsp_pop && !rsp_empty) begin
            if (scan_results_q.size() == 0) begin
               errors++;
               $error("result transfer with no scan result pending");
            end else begin
               want = scan_results_q.pop_front();
               results++;
               if (want.name_match) names++;
               if (want.manufacturer_found) manufs++;
               if (rsp_name_match !== want.name_match) begin
                  errors++;
                  $error("name_match: expected %0d, actual %0d",
                         want.name_match, rsp_name_match);
               end
               if (rsp_manufacturer_found !== want.manufacturer_found) begin
                  errors++;
                  $error("manufacturer_found: expected %0d, actual %0d",
                         want.manufacturer_found, rsp_manufacturer_found);
               end
               if (rsp_manufacturer_offset !== want.manufacturer_offset) begin
                  errors++;
                  $error("manufacturer_offset: expected %0d, actual %0d",
                         want.manufacturer_offset, rsp_manufacturer_offset);
               end
            end
         end
         if (req_push && !req_full) scan_byte(req_payload_byte, req_last_byte);
      end
      error_count   <= errors;
      pending_count <= scan_results_q.size();
      result_count  <= results;
      name_hits     <= names;
      manuf_hits    <= manufs;
   end

endmodule

FILE: verif/advertising_data_scanner_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the advertising data scanner core: payload stimulus, register setup and verdict.
module advertising_data_scanner_core_tb;
   import adsc_pkg::*;

   localparam int ITEM_TARGET   = 1400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [7:0] TYPE_FLAGS = 8'h01;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic [1:0] {
      POP_ALWAYS,
      POP_COIN,
      POP_SPARSE,
      POP_MOSTLY
   } pop_mode_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_push         = 1'b0;
   logic [7:0]             req_payload_byte = '0;
   logic                   req_last_byte    = 1'b0;
   logic                   rsp_pop          = 1'b0;
   logic                   csr_valid        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [63:0]            csr_data         = '0;
   logic                   csr_ready;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_name_match;
   logic                   rsp_manufacturer_found;
   logic [7:0]             rsp_manufacturer_offset;

   int error_count;
   int pending_count;
   int result_count;
   int name_hits;
   int manuf_hits;

   // what the registers hold, used to build matching elements
   logic [5:0]  cfg_name_length;
   logic [63:0] cfg_name_words [4];
   logic [7:0]  cfg_manuf_length;

   logic [7:0]   frame_q[$];
   int           bytes_sent    = 0;
   int           burst_left    = 0;
   int           settings_used = 0;
   int unsigned  cycle_count   = 0;
   int unsigned  pop_timer;
   pop_mode_type pop_mode;

   always #4 clock = ~clock;

   advertising_data_scanner_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_payload_byte        (req_payload_byte),
      .req_last_byte           (req_last_byte),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_name_match          (rsp_name_match),
      .rsp_manufacturer_found  (rsp_manufacturer_found),
      .rsp_manufacturer_offset (rsp_manufacturer_offset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   advertising_data_scanner_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_payload_byte        (req_payload_byte),
      .req_last_byte           (req_last_byte),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_name_match          (rsp_name_match),
      .rsp_manufacturer_found  (rsp_manufacturer_found),
      .rsp_manufacturer_offset (rsp_manufacturer_offset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .error_count             (error_count),
      .pending_count           (pending_count),
      .result_count            (result_count),
      .name_hits               (name_hits),
      .manuf_hits              (manuf_hits)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("advertising_data_scanner_core_tb: FAIL");
         $finish;
      end
   end

   // result side stalls: pop_timer periodically redraws the pop pattern at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         pop_timer <= 0;
         pop_mode  <= POP_ALWAYS;
      end else begin
         pop_timer <= pop_timer + 1;
         if (pop_timer % 48 == 47) pop_mode <= pop_mode_type'($urandom_range(0, 3));
         case (pop_mode)
            POP_ALWAYS: rsp_pop <= 1'b1;
            POP_COIN:   rsp_pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: rsp_pop <= (pop_timer % 7 == 0);
            default:    rsp_pop <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic logic [7:0] name_char(input int idx);
      if (idx < MAX_NAME_BYTES_DEFAULT) return cfg_name_words[idx / 8][(idx % 8) * 8 +: 8];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_push         <= 1'b1;
      req_payload_byte <= value;
      req_last_byte    <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   task automatic add_name_element(input logic [7:0] data_len, input bit corrupt);
      int          bad;
      logic [7:0]  flip;
      bad = (corrupt && data_len > 0) ? $urandom_range(0, data_len - 1) : -1;
      frame_q.push_back(data_len + 8'd1);
      frame_q.push_back(TYPE_NAME);
      for (int i = 0; i < data_len; i++) begin
         flip = (i == bad) ? 8'($urandom_range(1, 255)) : 8'h00;
         frame_q.push_back(name_char(i) ^ flip);
      end
   endtask

   // a zero length byte means the type byte and 255 data bytes follow it
   task automatic add_raw_element(input logic [7:0] len_byte, input logic [7:0] kind);
      int data_count;
      data_count = (len_byte == 8'd0) ? 255 : len_byte - 1;
      frame_q.push_back(len_byte);
      frame_q.push_back(kind);
      repeat (data_count) frame_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic build_frame();
      int cut;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2: add_name_element({2'b00, cfg_name_length}, $urandom_range(0, 2) == 0);
               3, 4:    add_raw_element(cfg_manuf_length + 8'd1, TYPE_MANUF);
               5:       add_name_element(8'($urandom_range(0, 6)), 1'b0);
               6:       add_raw_element(8'($urandom_range(1, 8)), TYPE_MANUF);
               7:       add_raw_element(($urandom_range(0, 40) == 0) ? 8'd0 :
                                        8'($urandom_range(1, 8)), 8'($urandom_range(0, 255)));
               default: add_raw_element(8'($urandom_range(1, 6)),
                                        ($urandom_range(0, 3) == 0) ? TYPE_NAME :
                                        8'($urandom_range(0, 255)));
            endcase
         end
         // payload may be cut short, possibly in the middle of an element
         if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            frame_q = frame_q[0:cut-1];
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // unused upper bits of the length registers carry junk
   task automatic configure(input logic [5:0] nlen, input logic [7:0] mlen, input bit spare);
      cfg_name_length  = nlen;
      cfg_manuf_length = mlen;
      for (int w = 0; w < 4; w++) begin
         case ($urandom_range(0, 5))
            0:       cfg_name_words[w] = '0;
            1:       cfg_name_words[w] = '1;
            default: cfg_name_words[w] = {$urandom, $urandom};
         endcase
      end
      csr_write(CSR_NAME_LENGTH, {$urandom, $urandom_range(0, 63) << 6 | nlen});
      csr_write(CSR_NAME_LOW, cfg_name_words[0]);
      csr_write(CSR_NAME_MID_LOW, cfg_name_words[1]);
      csr_write(CSR_NAME_MID_HI, cfg_name_words[2]);
      csr_write(CSR_NAME_HIGH, cfg_name_words[3]);
      csr_write(CSR_MANUF_LENGTH, {$urandom, 24'($urandom_range(0, 16777215)), mlen});
      if (spare) begin
         csr_write(CSR_SPARE_A, {$urandom, $urandom});
         csr_write(CSR_SPARE_B, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain_results();
      req_push  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [5:0] nlen;
      logic [7:0] mlen;
      int         phase_end;
      bit         wrap_done;
      cfg_name_length  = '0;
      cfg_manuf_length = '0;
      for (int w = 0; w < 4; w++) cfg_name_words[w] = '0;
      wrap_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty name matches, zero-length manufacturer element ends the payload
      frame_q = '{8'h01, TYPE_NAME, 8'h01, TYPE_MANUF};
      send_frame();
      // lone zero length byte
      frame_q = '{8'h00};
      send_frame();
      frame_q = '{8'h03, TYPE_NAME, 8'haa, 8'h55};
      send_frame();
      drain_results();

      // full-size name, cut short by the payload end
      configure(6'd32, 8'd255, 1'b1);
      frame_q = '{8'd33, TYPE_NAME};
      for (int i = 0; i < 10; i++) frame_q.push_back(name_char(i));
      send_frame();
      drain_results();

      // first name element decides; a later correct one is ignored
      configure(6'd1, 8'd0, 1'b0);
      frame_q = '{8'h02, TYPE_NAME, name_char(0) ^ 8'hff, 8'h02, TYPE_NAME, name_char(0)};
      send_frame();
      drain_results();

      while (bytes_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       nlen = 6'd0;
            1:       nlen = 6'd1;
            2:       nlen = 6'd32;
            3:       nlen = 6'd63;
            4:       nlen = 6'($urandom_range(33, 62));
            default: nlen = 6'($urandom_range(2, 31));
         endcase
         case ($urandom_range(0, 7))
            0:       mlen = 8'd0;
            1:       mlen = 8'd255;
            default: mlen = 8'($urandom_range(0, 12));
         endcase
         configure(nlen, mlen, $urandom_range(0, 3) == 0);
         if (!wrap_done) begin
            // manufacturer type byte at index 255 ends the payload: offset wraps to 0
            frame_q = '{8'd253, TYPE_FLAGS};
            repeat (252) frame_q.push_back(8'($urandom_range(0, 255)));
            frame_q.push_back(cfg_manuf_length + 8'd1);
            frame_q.push_back(TYPE_MANUF);
            send_frame();
            wrap_done = 1'b1;
         end
         phase_end = bytes_sent + $urandom_range(60, 160);
         while (bytes_sent < phase_end) begin
            build_frame();
            send_frame();
         end
         drain_results();
      end

      $display("covered %0d payload bytes over %0d register settings", bytes_sent,
               settings_used);
      $display("checked %0d scan results: %0d name matches, %0d manufacturer hits",
               result_count, name_hits, manuf_hits);
      if (error_count == 0 && pending_count == 0) begin
         $display("advertising_data_scanner_core_tb: PASS");
      end else begin
         $display("advertising_data_scanner_core_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: advertising_data_scanner_core.f
rtl/adsc_pkg.sv
rtl/adsc_fifo.sv
rtl/adsc_front.sv
rtl/adsc_back.sv
rtl/advertising_data_scanner_core.sv
verif/advertising_data_scanner_checker.sv
verif/advertising_data_scanner_core_tb.sv
